// File: rtl/core/omni_odo_pkg.sv
// Shared types and constants for the three-wheel omni odometry block.
// Item structs, register indexes, fixed-point constants, datapath step codes.
// No dependencies.
package omni_odo_pkg;

  typedef struct packed {
    logic signed [15:0] wheel_speed_0;
    logic signed [15:0] wheel_speed_1;
    logic signed [15:0] wheel_speed_2;
    logic        [15:0] time_step;
    logic               clear_pose;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] body_vx;
    logic signed [15:0] body_vy;
    logic signed [15:0] body_omega;
  } out_item_t;

  // config register indexes
  localparam logic [0:0] CFG_LINEAR_GAIN  = 1'b0;
  localparam logic [0:0] CFG_ANGULAR_GAIN = 1'b1;

  localparam logic [15:0] LINEAR_GAIN_RESET  = 16'd21845;
  localparam logic [15:0] ANGULAR_GAIN_RESET = 16'd4096;

  // 2/sqrt3 in Q16
  localparam logic [16:0] TWO_OVER_ROOT3 = 17'd75675;
  // 1/pi in Q32, split into a 15-bit high and a 16-bit low half
  localparam logic [14:0] INV_PI_HI = 15'd20860;
  localparam logic [15:0] INV_PI_LO = 16'd49591;

  // quarter-wave sine polynomial, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  // datapath micro-steps, issued in order by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_VX, OP_VY1, OP_OM, OP_VY2,
    OP_SZ, OP_SP1, OP_SP2, OP_SP3,
    OP_CZ, OP_CP1, OP_CP2, OP_CP3,
    OP_DX1, OP_DX2, OP_DX3,
    OP_DY1, OP_DY2, OP_DY3,
    OP_H1, OP_H2, OP_H3, OP_H4
  } op_t;

  typedef struct packed {
    logic load;     // capture input item, apply clear
    logic publish;  // copy pose and velocities to output register
    op_t  op;
  } cmd_t;

endpackage

// File: rtl/core/omni_forward_kinematics_odometry.sv
// Top level of the three-wheel omni forward kinematics and odometry block.
// Depends on omni_odo_pkg, omni_odo_ctrl and omni_odo_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transaction carries
//   three wheel speeds, a time step and a clear flag. Output channel
//   (out_valid / out_stall / out_data): one transaction per input item with
//   the updated pose and the body velocities of that item.
//   Config port: cfg_we writes cfg_data to register cfg_index (0 linear gain,
//   1 angular gain) at the clock edge; write only while the block is idle.
// Sequence:
//   After the accepting edge the item runs through 22 steps on the
//   single shared 36x18 multiplier (velocities, sine and cosine polynomials,
//   position and heading updates) and then a publish step; out_valid is registered.
//   The next item is accepted only once the controller is back in idle, the
//   cycle after publish; in_stall stays high until then.
// Reset (rst, synchronous): gains return to their defaults, pose and
//   velocities to zero, output channel empty.
// Stall: the result sits in an output register. A new item can be accepted
//   and worked on while it waits; that item's publish waits until the
//   register is taken, and in_stall stays high meanwhile.
module omni_forward_kinematics_odometry import omni_odo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;

  // sequencer: handshake and step order
  omni_odo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic, pose state and output register
  omni_odo_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/omni_odo_dp.sv
// Datapath: gains, pose state, one shared 36x18 multiplier and step logic.
// Depends on omni_odo_pkg; driven by omni_odo_ctrl commands.
module omni_odo_dp import omni_odo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output out_item_t   out_data
);

  function automatic logic signed [15:0] sat16(input logic signed [53:0] v);
    if (v > 54'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -54'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
    if (v > 54'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -54'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic        [15:0] linear_gain;
  logic        [15:0] angular_gain;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic        [15:0] heading_angle;
  logic signed [15:0] velocity_x;
  logic signed [15:0] velocity_y;
  logic signed [15:0] angular_rate;

  logic signed [17:0] e_vx;
  logic signed [16:0] e_vy;
  logic signed [17:0] e_om;
  logic        [15:0] dt;
  logic signed [53:0] prod;
  logic signed [35:0] tmp;
  logic        [14:0] z2;
  logic signed [16:0] sin_val;
  logic signed [16:0] cos_val;
  logic signed [63:0] acc;

  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;

  logic        [15:0] cos_ang;
  logic        [14:0] xq_s;
  logic        [14:0] xq_c;
  logic        [14:0] prod_z;
  logic        [16:0] poly1;
  logic        [16:0] poly2;
  logic        [16:0] q_mag;
  logic        [16:0] q_mag_c;
  logic signed [16:0] sin_next;
  logic signed [16:0] cos_next;

  logic signed [53:0] rnd_vx;
  logic signed [53:0] rnd_vy;
  logic signed [53:0] rnd_om;
  logic signed [53:0] rnd_pos;
  logic signed [53:0] x_sum;
  logic signed [53:0] y_sum;
  logic signed [63:0] h_sum;
  logic signed [17:0] w0;
  logic signed [17:0] w1;
  logic signed [17:0] w2;

  // quarter-wave folding for sine (heading) and cosine (heading + pi/2)
  assign cos_ang = heading_angle + 16'd16384;
  assign xq_s = heading_angle[14] ? 15'd16384 - {1'b0, heading_angle[13:0]}
                                  : {1'b0, heading_angle[13:0]};
  assign xq_c = cos_ang[14] ? 15'd16384 - {1'b0, cos_ang[13:0]}
                            : {1'b0, cos_ang[13:0]};

  // polynomial intermediate terms (small unsigned values) and signed sine and cosine results
  assign prod_z  = prod[28:14];
  assign poly1   = SIN_B - {4'b0000, prod[26:14]};
  assign poly2   = SIN_A - prod[30:14];
  assign q_mag   = prod[31:15];
  assign q_mag_c = (q_mag > 17'd32768) ? 17'd32768 : q_mag;
  assign sin_next = heading_angle[15] ? -$signed(q_mag_c) : $signed(q_mag_c);
  assign cos_next = cos_ang[15] ? -$signed(q_mag_c) : $signed(q_mag_c);

  // round to nearest, ties up: add half then arithmetic shift
  assign rnd_vx  = (prod + 54'sd32768) >>> 16;
  assign rnd_vy  = (prod + 54'sd2147483648) >>> 32;
  assign rnd_om  = (prod + 54'sd4096) >>> 13;
  assign rnd_pos = (prod + 54'sd67108864) >>> 27;
  assign x_sum   = {{22{x_position[31]}}, x_position} + rnd_pos;
  assign y_sum   = {{22{y_position[31]}}, y_position} + rnd_pos;
  assign h_sum   = acc + ({{10{prod[53]}}, prod} <<< 16) + 64'sd8796093022208;

  assign w0 = {{2{in_data.wheel_speed_0[15]}}, in_data.wheel_speed_0};
  assign w1 = {{2{in_data.wheel_speed_1[15]}}, in_data.wheel_speed_1};
  assign w2 = {{2{in_data.wheel_speed_2[15]}}, in_data.wheel_speed_2};

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_VX: begin
        mul_a = {{18{e_vx[17]}}, e_vx};
        mul_b = {2'b00, linear_gain};
      end
      OP_VY1: begin
        mul_a = {{19{e_vy[16]}}, e_vy};
        mul_b = {2'b00, linear_gain};
      end
      OP_OM: begin
        mul_a = {{18{e_om[17]}}, e_om};
        mul_b = {2'b00, angular_gain};
      end
      OP_VY2: begin
        mul_a = tmp;
        mul_b = {1'b0, TWO_OVER_ROOT3};
      end
      OP_SZ: begin
        mul_a = {21'd0, xq_s};
        mul_b = {3'd0, xq_s};
      end
      OP_CZ: begin
        mul_a = {21'd0, xq_c};
        mul_b = {3'd0, xq_c};
      end
      OP_SP1, OP_CP1: begin
        mul_a = {21'd0, prod_z};
        mul_b = {5'd0, SIN_C};
      end
      OP_SP2, OP_CP2: begin
        mul_a = {21'd0, z2};
        mul_b = {1'b0, poly1};
      end
      OP_SP3: begin
        mul_a = {21'd0, xq_s};
        mul_b = {1'b0, poly2};
      end
      OP_CP3: begin
        mul_a = {21'd0, xq_c};
        mul_b = {1'b0, poly2};
      end
      OP_DX1: begin
        mul_a = {{20{velocity_y[15]}}, velocity_y};
        mul_b = {sin_val[16], sin_val};
      end
      OP_DX2: begin
        mul_a = {{20{velocity_x[15]}}, velocity_x};
        mul_b = {cos_val[16], cos_val};
      end
      OP_DX3: begin
        mul_a = prod[35:0] - tmp;
        mul_b = {2'b00, dt};
      end
      OP_DY1: begin
        mul_a = {{20{velocity_x[15]}}, velocity_x};
        mul_b = {sin_val[16], sin_val};
      end
      OP_DY2: begin
        mul_a = {{20{velocity_y[15]}}, velocity_y};
        mul_b = {cos_val[16], cos_val};
      end
      OP_DY3: begin
        mul_a = prod[35:0] + tmp;
        mul_b = {2'b00, dt};
      end
      OP_H1: begin
        mul_a = {{20{angular_rate[15]}}, angular_rate};
        mul_b = {2'b00, dt};
      end
      OP_H2: begin
        mul_a = prod[35:0];
        mul_b = {2'b00, INV_PI_LO};
      end
      OP_H3: begin
        mul_a = tmp;
        mul_b = {3'b000, INV_PI_HI};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // gains and odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain   <= LINEAR_GAIN_RESET;
      angular_gain  <= ANGULAR_GAIN_RESET;
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      velocity_x    <= '0;
      velocity_y    <= '0;
      angular_rate  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINEAR_GAIN:  linear_gain  <= cfg_data;
          CFG_ANGULAR_GAIN: angular_gain <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && in_data.clear_pose) begin
        x_position    <= '0;
        y_position    <= '0;
        heading_angle <= '0;
      end
      case (cmd.op)
        OP_VY1: velocity_x    <= sat16(rnd_vx);
        OP_VY2: angular_rate  <= sat16(rnd_om);
        OP_SZ:  velocity_y    <= sat16(rnd_vy);
        OP_DY1: x_position    <= sat32(x_sum);
        OP_H1:  y_position    <= sat32(y_sum);
        OP_H4:  heading_angle <= heading_angle + h_sum[59:44];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      e_vx <= (w2 <<< 1) - w0 - w1;
      e_vy <= w1[16:0] - w0[16:0];
      e_om <= w0 + w1 + w2;
      dt   <= in_data.time_step;
    end
    case (cmd.op)
      OP_OM, OP_DX2, OP_DY2, OP_H2: tmp <= prod[35:0];
      OP_SP1, OP_CP1:               z2  <= prod_z;
      OP_CZ:                        sin_val <= sin_next;
      OP_DX1:                       cos_val <= cos_next;
      OP_H3:                        acc <= {{10{prod[53]}}, prod};
      default: ;
    endcase
    if (cmd.publish) begin
      out_data.pos_x      <= x_position;
      out_data.pos_y      <= y_position;
      out_data.heading    <= heading_angle;
      out_data.body_vx    <= velocity_x;
      out_data.body_vy    <= velocity_y;
      out_data.body_omega <= angular_rate;
    end
  end

endmodule

// File: rtl/core/omni_odo_ctrl.sv
// Controller: handshake state machine and step sequencer for the datapath.
// Depends on omni_odo_pkg.
module omni_odo_ctrl import omni_odo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  op_t    step;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !(out_valid && out_stall);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.publish = 1'b0;
    cmd.op      = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.op = step;
        if (step == OP_H4) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step <= OP_VX;
      end else if (state == ST_RUN && step != OP_H4) begin
        step <= op_t'(step + 5'd1);
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
